// ===== design/hsv_colour_ramp_generator_assert.svh =====
// Assertion macros for the HSV colour ramp generator checker.
`ifndef HSV_COLOUR_RAMP_GENERATOR_ASSERT_SVH
`define HSV_COLOUR_RAMP_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcrg assertion failed");

// Next-cycle implication.
`define HCRG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcrg assertion failed");

// Implication after a fixed number of cycles.
`define HCRG_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("hcrg assertion failed");

`endif

// ===== design/hcrg_pkg.sv =====
// Shared types and constants of the HSV colour ramp generator.
package hcrg_pkg;

	localparam int HUE_W  = 16;
	localparam int SV_W   = 17;
	localparam int IDX_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Shared multiplier operand width and the reciprocal of 255 for 26-bit dividends.
	localparam int                MUL_W      = 27;
	localparam logic [MUL_W-1:0]  RECIP_255  = 27'd67372037;
	localparam int                RCP_SHIFT  = 34;
	localparam logic [7:0]        FLOOR_BIAS = 8'd254;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_START    = 3'd0,
		REG_SAT_START    = 3'd1,
		REG_BRIGHT_START = 3'd2,
		REG_HUE_END      = 3'd3,
		REG_SAT_END      = 3'd4,
		REG_BRIGHT_END   = 3'd5,
		REG_LAST_ENTRY   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_start;
		logic [SV_W-1:0]  sat_start;
		logic [SV_W-1:0]  bright_start;
		logic [HUE_W-1:0] hue_end;
		logic [SV_W-1:0]  sat_end;
		logic [SV_W-1:0]  bright_end;
		logic [IDX_W-1:0] last_entry;
	} cfg_t;

	// Datapath micro-operations, one per cycle of an entry; FIN holds while a full output register stalls.
	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_KD_HUE,
		UOP_RCP_HUE,
		UOP_KD_SAT,
		UOP_RCP_SAT,
		UOP_KD_BRT,
		UOP_RCP_BRT,
		UOP_SF,
		UOP_SG,
		UOP_P,
		UOP_Q,
		UOP_T,
		UOP_FIN
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t uop;
		logic load_out;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	function automatic uop_t next_uop(input uop_t u);
		uop_t n;
		unique case (u)
			UOP_KD_HUE:  n = UOP_RCP_HUE;
			UOP_RCP_HUE: n = UOP_KD_SAT;
			UOP_KD_SAT:  n = UOP_RCP_SAT;
			UOP_RCP_SAT: n = UOP_KD_BRT;
			UOP_KD_BRT:  n = UOP_RCP_BRT;
			UOP_RCP_BRT: n = UOP_SF;
			UOP_SF:      n = UOP_SG;
			UOP_SG:      n = UOP_P;
			UOP_P:       n = UOP_Q;
			UOP_Q:       n = UOP_T;
			default:     n = UOP_FIN;
		endcase
		return n;
	endfunction

endpackage

// ===== design/hcrg_ctrl.sv =====
// Controller: sequences the micro-operations of one entry and owns the handshakes.
module hcrg_ctrl import hcrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	uop_t        uop_q, uop_d;
	logic        m_valid_q, m_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			uop_q     <= UOP_NONE;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			uop_q     <= uop_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		uop_d        = uop_q;
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.uop      = UOP_NONE;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
					uop_d     = UOP_KD_HUE;
				end
			end
			ST_RUN: begin
				cmd.uop = uop_q;
				if (uop_q == UOP_FIN) begin
					// hold the finished entry until the output register frees up
					if (!m_valid_q || m_tready) begin
						cmd.load_out = 1'b1;
						state_d      = ST_IDLE;
						uop_d        = UOP_NONE;
					end
				end else begin
					uop_d = next_uop(uop_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
				uop_d   = UOP_NONE;
			end
		endcase
		m_valid_d = cmd.load_out | (m_valid_q & ~m_tready);
	end

	assign m_tvalid = m_valid_q;

endmodule

// ===== design/hcrg_dpath.sv =====
// Datapath: interpolation, HSV to RGB conversion on one shared multiplier, output register.
module hcrg_dpath import hcrg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  cfg_t             cfg,
	input  logic             restart,
	output logic [IDX_W-1:0] entry_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             is_last
);

	localparam int MW     = FRAC_BITS + 1;
	localparam int CW     = (MW > SV_W) ? MW : SV_W;
	localparam int PW     = SV_W + MW;
	localparam int PROD_W = 2 * MUL_W;
	localparam logic [CW-1:0]   ONE   = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [PW+7:0]   SAT_L = (PW+8)'(255);
	localparam logic [SV_W+7:0] V_LIM = (SV_W+8)'(255);

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	logic [IDX_W-1:0]  step_q, k_q, k_sel;
	logic              last_q;
	logic [PROD_W-1:0] prod_q, mul_p;
	logic [HUE_W-1:0]  hue_q;
	logic [SV_W-1:0]   sat_q, brt_q, sf_q, sg_q;
	logic [7:0]        p_q, q_q;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic              mul_en;
	logic              neg_h, neg_s, neg_b;
	logic [SV_W-1:0]   mag_h, mag_s, mag_b;
	logic [SV_W-1:0]   hue_ip;
	logic [17:0]       quot;
	logic [18:0]       h6;
	logic [HUE_W-1:0]  frac;
	logic [7:0]        v8, t8;
	logic [SV_W+7:0]   v_wide, v_sh;

	function automatic logic [SV_W-1:0] mag(input logic [SV_W-1:0] a, input logic [SV_W-1:0] b);
		return (b >= a) ? (b - a) : (a - b);
	endfunction

	// start plus or minus the quotient, which is rounded so that the result is floored
	function automatic logic [SV_W-1:0] interp(input logic [SV_W-1:0] start, input logic neg,
		input logic [17:0] q);
		logic [17:0] sum;
		sum = neg ? ({1'b0, start} - q) : ({1'b0, start} + q);
		return sum[SV_W-1:0];
	endfunction

	// one minus x, clamped at zero
	function automatic logic [MW-1:0] one_minus(input logic [SV_W-1:0] x);
		logic [CW-1:0] xe;
		xe = CW'(x);
		return (xe >= ONE) ? '0 : MW'(ONE - xe);
	endfunction

	// 255 * product / one^2, saturated to 8 bits
	function automatic logic [7:0] scale(input logic [PW-1:0] x);
		logic [PW+7:0] w;
		logic [PW+7:0] sh;
		w  = {x, 8'b0} - {8'b0, x};
		sh = w >> (2 * FRAC_BITS);
		return (sh > SAT_L) ? 8'hFF : sh[7:0];
	endfunction

	assign neg_h = cfg.hue_end < cfg.hue_start;
	assign neg_s = cfg.sat_end < cfg.sat_start;
	assign neg_b = cfg.bright_end < cfg.bright_start;
	assign mag_h = mag({1'b0, cfg.hue_start}, {1'b0, cfg.hue_end});
	assign mag_s = mag(cfg.sat_start, cfg.sat_end);
	assign mag_b = mag(cfg.bright_start, cfg.bright_end);
	assign quot  = prod_q[RCP_SHIFT +: 18];

	assign hue_ip = interp({1'b0, cfg.hue_start}, neg_h, quot);

	assign h6   = {1'b0, hue_q, 2'b0} + {2'b0, hue_q, 1'b0};
	assign frac = h6[HUE_W-1:0];

	assign k_sel = restart ? '0 : step_q;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = !(cmd.uop inside {UOP_NONE, UOP_FIN});
		case (cmd.uop)
			UOP_KD_HUE: begin
				mul_a = MUL_W'(k_q);
				mul_b = MUL_W'(mag_h);
			end
			UOP_KD_SAT: begin
				mul_a = MUL_W'(k_q);
				mul_b = MUL_W'(mag_s);
			end
			UOP_KD_BRT: begin
				mul_a = MUL_W'(k_q);
				mul_b = MUL_W'(mag_b);
			end
			UOP_RCP_HUE: begin
				mul_a = MUL_W'(prod_q[25:0] + (neg_h ? 26'(FLOOR_BIAS) : 26'd0));
				mul_b = RECIP_255;
			end
			UOP_RCP_SAT: begin
				mul_a = MUL_W'(prod_q[25:0] + (neg_s ? 26'(FLOOR_BIAS) : 26'd0));
				mul_b = RECIP_255;
			end
			UOP_RCP_BRT: begin
				mul_a = MUL_W'(prod_q[25:0] + (neg_b ? 26'(FLOOR_BIAS) : 26'd0));
				mul_b = RECIP_255;
			end
			UOP_SF: begin
				mul_a = MUL_W'(sat_q);
				mul_b = MUL_W'(frac);
			end
			UOP_SG: begin
				mul_a = MUL_W'(sat_q);
				mul_b = MUL_W'(17'h10000 - {1'b0, frac});
			end
			UOP_P: begin
				mul_a = MUL_W'(brt_q);
				mul_b = MUL_W'(one_minus(sat_q));
			end
			UOP_Q: begin
				mul_a = MUL_W'(brt_q);
				mul_b = MUL_W'(one_minus(sf_q));
			end
			UOP_T: begin
				mul_a = MUL_W'(brt_q);
				mul_b = MUL_W'(one_minus(sg_q));
			end
			default: ;
		endcase
	end

	assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.start) begin
			step_q <= (k_sel == cfg.last_entry) ? '0 : k_sel + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			k_q    <= k_sel;
			last_q <= (k_sel == cfg.last_entry);
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		// capture the product of the previous micro-operation
		case (cmd.uop)
			UOP_KD_SAT: hue_q <= hue_ip[HUE_W-1:0];
			UOP_KD_BRT: sat_q <= interp(cfg.sat_start, neg_s, quot);
			UOP_SF:     brt_q <= interp(cfg.bright_start, neg_b, quot);
			UOP_SG:     sf_q  <= prod_q[32:16];
			UOP_P:      sg_q  <= prod_q[32:16];
			UOP_Q:      p_q   <= scale(prod_q[PW-1:0]);
			UOP_T:      q_q   <= scale(prod_q[PW-1:0]);
			default: ;
		endcase
	end

	assign t8     = scale(prod_q[PW-1:0]);
	assign v_wide = {brt_q, 8'b0} - {8'b0, brt_q};
	assign v_sh   = v_wide >> FRAC_BITS;
	assign v8     = (v_sh > V_LIM) ? 8'hFF : v_sh[7:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			entry_index <= k_q;
			is_last     <= last_q;
			case (sector_t'(h6[18:16]))
				SEC_R_Y: begin red <= v8;  green <= t8;  blue <= p_q; end
				SEC_Y_G: begin red <= q_q; green <= v8;  blue <= p_q; end
				SEC_G_C: begin red <= p_q; green <= v8;  blue <= t8;  end
				SEC_C_B: begin red <= p_q; green <= q_q; blue <= v8;  end
				SEC_B_M: begin red <= t8;  green <= p_q; blue <= v8;  end
				default: begin red <= v8;  green <= p_q; blue <= q_q; end
			endcase
		end
	end

endmodule

// ===== design/hsv_colour_ramp_generator.sv =====
// Top level of the HSV colour ramp generator: configuration registers and stream ports.
// An accepted item steps through the micro-operations KD_HUE to T, then FIN, and is
// loaded into the output register once it is free; s_tready comes back high in the same
// cycle as m_tvalid. No new item is taken until then, since the single shared 27x27
// multiplier forms eleven products per entry in sequence.
// Reset (arst_n, asynchronous, active low): configuration to its reset values, entry
// counter to zero, controller idle, output register empty.
module hsv_colour_ramp_generator import hcrg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// step requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	// palette entries
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [7:0] entry_index, [15:8] red,
	                                         // [23:16] green, [31:24] blue
	output logic                  m_tlast    // is_last
);

	cfg_t             cfg_q;
	cmd_t             cmd;
	logic [IDX_W-1:0] entry_index;
	logic [7:0]       red, green, blue;

	// Writes always land; the datapath reads the registers all through an item, so
	// write them only while no item is in flight.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_start    <= '0;
			cfg_q.sat_start    <= 17'h10000;
			cfg_q.bright_start <= 17'h10000;
			cfg_q.hue_end      <= '0;
			cfg_q.sat_end      <= 17'h10000;
			cfg_q.bright_end   <= 17'h10000;
			cfg_q.last_entry   <= 8'hFF;
		end else if (cfg_valid) begin
			// drop writes to indexes past the register list
			unique case (reg_idx_t'(cfg_index))
				REG_HUE_START:    cfg_q.hue_start    <= cfg_data[HUE_W-1:0];
				REG_SAT_START:    cfg_q.sat_start    <= cfg_data[SV_W-1:0];
				REG_BRIGHT_START: cfg_q.bright_start <= cfg_data[SV_W-1:0];
				REG_HUE_END:      cfg_q.hue_end      <= cfg_data[HUE_W-1:0];
				REG_SAT_END:      cfg_q.sat_end      <= cfg_data[SV_W-1:0];
				REG_BRIGHT_END:   cfg_q.bright_end   <= cfg_data[SV_W-1:0];
				REG_LAST_ENTRY:   cfg_q.last_entry   <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	hcrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hcrg_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.restart     (s_tdata[0]),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.is_last     (m_tlast)
	);

	assign m_tdata = {blue, green, red, entry_index};

endmodule

// ===== design/hcrg_checker.sv =====
// Port-level checker for the HSV colour ramp generator, bound to the top level.
`include "hsv_colour_ramp_generator_assert.svh"

module hcrg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// a stalled entry holds its payload
	`HCRG_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// one item at a time: no new request right after one is taken
	`HCRG_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a fresh entry only appears at the end of a computation
	`HCRG_ASSERT_IMP(a_out_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

	// restart with a free output gives entry zero when the result is loaded out
	`HCRG_ASSERT_DLY(a_restart_zero, clk, arst_n, s_tvalid && s_tready && s_tdata[0] && (!m_tvalid || m_tready), 13, m_tvalid && (m_tdata[7:0] == 8'd0))

endmodule

bind hsv_colour_ramp_generator hcrg_checker u_hcrg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
